/* sv/axis_angle_rotation_matrix_top_assert.svh */
// Assertion macros for the axis-angle rotation matrix block.
// Expects clk and rst in the scope where a macro is used.
`ifndef AXIS_ANGLE_ROTATION_MATRIX_TOP_ASSERT_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_TOP_ASSERT_SVH

// Check a consequence in the same cycle as its cause
`define AAR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence a fixed number of cycles after its cause
`define AAR_ASSERT_LATER(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

/* sv/aar_pkg.sv */
// Package for the axis-angle rotation matrix block: sizes, CORDIC table and
// the request and result structs. No dependencies.
package aar_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int AXIS_BITS    = 16;
  localparam int FRAC_BITS    = 14;
  localparam int CORDIC_STEPS = 16;
  localparam int OUT_BITS     = FRAC_BITS + 2;

  // Integer square root of a 64-bit sum, one result bit per stage
  localparam int ROOT_STEPS = 32;
  // Restoring division, one quotient bit per stage
  localparam int DIV_STEPS  = 32;

  localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sd652032874;
  localparam logic signed [OUT_BITS-1:0] Q_ONE = OUT_BITS'(1 << FRAC_BITS);

  // Arctangent of 2^-i in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic        [ANGLE_BITS-1:0] angle;
    logic signed [AXIS_BITS-1:0]  axis_x;
    logic signed [AXIS_BITS-1:0]  axis_y;
    logic signed [AXIS_BITS-1:0]  axis_z;
  } aar_in_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] r00;
    logic signed [OUT_BITS-1:0] r01;
    logic signed [OUT_BITS-1:0] r02;
    logic signed [OUT_BITS-1:0] r10;
    logic signed [OUT_BITS-1:0] r11;
    logic signed [OUT_BITS-1:0] r12;
    logic signed [OUT_BITS-1:0] r20;
    logic signed [OUT_BITS-1:0] r21;
    logic signed [OUT_BITS-1:0] r22;
    logic                       degenerate;
  } aar_out_t;

endpackage

/* sv/axis_angle_rotation_matrix_top.sv */
// Axis-angle to 3x3 rotation matrix, fully pipelined.
// Depends on aar_pkg and axis_angle_rotation_matrix_top_assert.svh.
//
//   channel  | ports                 | transfer
//   ---------+-----------------------+--------------------------------
//   request  | start, item, busy     | clock edge with start & !busy
//   result   | done, result          | clock edge with done high
//
// One request may enter every cycle; busy stays low.
// The delay from request to result is set mostly by the
// 32-stage square root and the 32-stage divider in series.
// Reset (rst, synchronous) clears the valid bits, dropping requests in flight; otherwise
// no result is lost or repeated, and results leave in request order.
`include "axis_angle_rotation_matrix_top_assert.svh"

module axis_angle_rotation_matrix_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  aar_pkg::aar_in_t  item,
  output logic              busy,
  output logic              done,
  output aar_pkg::aar_out_t result
);
  import aar_pkg::*;

  localparam int ANG_DLY = 5 + ROOT_STEPS;
  localparam int NEG_DLY = ANG_DLY + 1 + DIV_STEPS;
  localparam int LAT     = NEG_DLY + 6;

  // Round Q60 to the output fraction and saturate to +-1.0
  function automatic logic signed [OUT_BITS-1:0] to_out(input logic signed [71:0] e);
    logic signed [71:0] v;
    v = (e + (72'sd1 <<< (59 - FRAC_BITS))) >>> (60 - FRAC_BITS);
    if (v > 72'(Q_ONE)) to_out = Q_ONE;
    else if (v < -72'(Q_ONE)) to_out = -Q_ONE;
    else to_out = OUT_BITS'(v);
  endfunction

  logic [LAT-1:0] vld;
  logic           zl    [LAT-1];
  logic [2:0]     neg_l [NEG_DLY];
  logic [ANGLE_BITS-1:0] ang_l [ANG_DLY];

  logic [AXIS_BITS-1:0] ax_in [3];
  assign ax_in[0] = item.axis_x;
  assign ax_in[1] = item.axis_y;
  assign ax_in[2] = item.axis_z;

  assign busy = 1'b0;
  assign done = vld[LAT-1];

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start};
    end
  end

  // Delay lines for side data
  always_ff @(posedge clk) begin
    zl[0]    <= (ax_in[0] == '0) && (ax_in[1] == '0) && (ax_in[2] == '0);
    neg_l[0] <= {ax_in[2][AXIS_BITS-1], ax_in[1][AXIS_BITS-1], ax_in[0][AXIS_BITS-1]};
    ang_l[0] <= item.angle;
    for (int i = 1; i < LAT - 1; i++) zl[i] <= zl[i-1];
    for (int i = 1; i < NEG_DLY; i++) neg_l[i] <= neg_l[i-1];
    for (int i = 1; i < ANG_DLY; i++) ang_l[i] <= ang_l[i-1];
  end

  // Stage A: magnitudes
  logic [AXIS_BITS-1:0] a_mag [3];
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      a_mag[k] <= ax_in[k][AXIS_BITS-1] ? AXIS_BITS'(~ax_in[k] + 1'b1) : ax_in[k];
    end
  end

  // Stage B: shift that puts the largest magnitude in [2^30, 2^31)
  logic [AXIS_BITS-1:0] m_max;
  logic [31:0]          m32;
  logic [4:0]           lead;
  logic [AXIS_BITS-1:0] b_mag [3];
  logic [4:0]           b_sh;

  always_comb begin
    m_max = a_mag[0];
    if (a_mag[1] > m_max) m_max = a_mag[1];
    if (a_mag[2] > m_max) m_max = a_mag[2];
    m32  = 32'(m_max);
    lead = '0;
    for (int i = 0; i < 32; i++) begin
      if (m32[i]) lead = 5'(31 - i);
    end
  end

  always_ff @(posedge clk) begin
    b_mag <= a_mag;
    b_sh  <= (lead == '0) ? '0 : lead - 5'd1;
  end

  // Stage C: block shift
  logic [31:0] c_mag [3];
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) c_mag[k] <= 32'(b_mag[k]) << b_sh;
  end

  // Stage D: squares
  logic [63:0] d_sq  [3];
  logic [31:0] d_mag [3];
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) d_sq[k] <= {32'b0, c_mag[k]} * {32'b0, c_mag[k]};
    d_mag <= c_mag;
  end

  // Square root: one result bit per stage
  logic [63:0] rt_n   [ROOT_STEPS+1];
  logic [63:0] rt_res [ROOT_STEPS+1];
  logic [31:0] rt_mag [ROOT_STEPS+1][3];

  always_ff @(posedge clk) begin
    rt_n[0]   <= d_sq[0] + d_sq[1] + d_sq[2];
    rt_res[0] <= '0;
    rt_mag[0] <= d_mag;
  end

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    localparam logic [63:0] RBIT = 64'(1) << (62 - 2 * k);
    logic [64:0] trial;
    assign trial = {1'b0, rt_res[k]} + {1'b0, RBIT};
    always_ff @(posedge clk) begin
      if ({1'b0, rt_n[k]} >= trial) begin
        rt_n[k+1]   <= rt_n[k] - trial[63:0];
        rt_res[k+1] <= (rt_res[k] >> 1) + RBIT;
      end else begin
        rt_n[k+1]   <= rt_n[k];
        rt_res[k+1] <= rt_res[k] >> 1;
      end
      rt_mag[k+1] <= rt_mag[k];
    end
  end

  // Division: one quotient bit per stage, CORDIC alongside
  logic [63:0] dv_rem [DIV_STEPS+1][3];
  logic [31:0] dv_q   [DIV_STEPS+1][3];
  logic [31:0] dv_r   [DIV_STEPS+1];
  logic signed [33:0] cs_x [DIV_STEPS+1];
  logic signed [33:0] cs_y [DIV_STEPS+1];
  logic signed [33:0] cs_z [DIV_STEPS+1];
  logic [1:0]         cs_q [DIV_STEPS+1];

  logic [31:0] a32;
  logic [31:0] a_rnd;
  logic [31:0] z_fold;

  // Fold the angle into the quadrant around zero
  always_comb begin
    a32    = 32'(ang_l[ANG_DLY-1]) << (32 - ANGLE_BITS);
    a_rnd  = a32 + 32'h2000_0000;
    z_fold = a32 - {a_rnd[31:30], 30'b0};
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      dv_rem[0][k] <= (64'(rt_mag[ROOT_STEPS][k]) << 30) + 64'(rt_res[ROOT_STEPS][31:1]);
      dv_q[0][k]   <= '0;
    end
    dv_r[0] <= rt_res[ROOT_STEPS][31:0];
    cs_x[0] <= CORDIC_GAIN_INV;
    cs_y[0] <= '0;
    cs_z[0] <= 34'($signed(z_fold));
    cs_q[0] <= a_rnd[31:30];
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int QB = DIV_STEPS - 1 - j;
    logic [63:0] dsh;
    assign dsh = 64'(dv_r[j]) << QB;
    always_ff @(posedge clk) begin
      for (int k = 0; k < 3; k++) begin
        if (dv_rem[j][k] >= dsh) begin
          dv_rem[j+1][k] <= dv_rem[j][k] - dsh;
          dv_q[j+1][k]   <= dv_q[j][k] | (32'(1) << QB);
        end else begin
          dv_rem[j+1][k] <= dv_rem[j][k];
          dv_q[j+1][k]   <= dv_q[j][k];
        end
      end
      dv_r[j+1] <= dv_r[j];
      cs_q[j+1] <= cs_q[j];
    end

    if (j < CORDIC_STEPS) begin : g_rot
      localparam logic signed [33:0] AT = $signed({2'b00, ATAN_TURNS[j]});
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      assign dx = cs_y[j] >>> j;
      assign dy = cs_x[j] >>> j;
      // Rotate toward zero residual angle
      always_ff @(posedge clk) begin
        if (!cs_z[j][33]) begin
          cs_x[j+1] <= cs_x[j] - dx;
          cs_y[j+1] <= cs_y[j] + dy;
          cs_z[j+1] <= cs_z[j] - AT;
        end else begin
          cs_x[j+1] <= cs_x[j] + dx;
          cs_y[j+1] <= cs_y[j] - dy;
          cs_z[j+1] <= cs_z[j] + AT;
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk) begin
        cs_x[j+1] <= cs_x[j];
        cs_y[j+1] <= cs_y[j];
        cs_z[j+1] <= cs_z[j];
      end
    end
  end

  // P1: signed unit components, quadrant unfold
  logic signed [33:0] cq_c;
  logic signed [33:0] cq_s;
  logic signed [31:0] p1_u [3];
  logic signed [33:0] p1_c;
  logic signed [33:0] p1_s;
  logic signed [34:0] p1_t;

  always_comb begin
    unique case (cs_q[DIV_STEPS])
      2'd0: begin cq_c = cs_x[DIV_STEPS];  cq_s = cs_y[DIV_STEPS];  end
      2'd1: begin cq_c = -cs_y[DIV_STEPS]; cq_s = cs_x[DIV_STEPS];  end
      2'd2: begin cq_c = -cs_x[DIV_STEPS]; cq_s = -cs_y[DIV_STEPS]; end
      2'd3: begin cq_c = cs_y[DIV_STEPS];  cq_s = -cs_x[DIV_STEPS]; end
      default: begin cq_c = cs_x[DIV_STEPS]; cq_s = cs_y[DIV_STEPS]; end
    endcase
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      logic [31:0] qc;
      qc = (dv_q[DIV_STEPS][k] > 32'h4000_0000) ? 32'h4000_0000 : dv_q[DIV_STEPS][k];
      p1_u[k] <= neg_l[NEG_DLY-1][k] ? -$signed(qc) : $signed(qc);
    end
    p1_c <= cq_c;
    p1_s <= cq_s;
    p1_t <= 35'sh4000_0000 - 35'(cq_c);
  end

  // P2: products u_i*u_j and u_k*s
  logic signed [63:0] p2_uu [6];
  logic signed [65:0] p2_us [3];
  logic signed [33:0] p2_c;
  logic signed [34:0] p2_t;
  always_ff @(posedge clk) begin
    p2_uu[0] <= p1_u[0] * p1_u[0];
    p2_uu[1] <= p1_u[1] * p1_u[1];
    p2_uu[2] <= p1_u[2] * p1_u[2];
    p2_uu[3] <= p1_u[0] * p1_u[1];
    p2_uu[4] <= p1_u[0] * p1_u[2];
    p2_uu[5] <= p1_u[1] * p1_u[2];
    for (int k = 0; k < 3; k++) p2_us[k] <= p1_u[k] * p1_s;
    p2_c <= p1_c;
    p2_t <= p1_t;
  end

  // P3: round u_i*u_j to Q30
  logic signed [34:0] p3_uu [6];
  logic signed [65:0] p3_us [3];
  logic signed [33:0] p3_c;
  logic signed [34:0] p3_t;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) p3_uu[i] <= 35'((p2_uu[i] + 64'sh2000_0000) >>> 30);
    p3_us <= p2_us;
    p3_c  <= p2_c;
    p3_t  <= p2_t;
  end

  // P4: scale by 1 - cos
  logic signed [69:0] p4_e  [6];
  logic signed [65:0] p4_us [3];
  logic signed [33:0] p4_c;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) p4_e[i] <= p3_uu[i] * p3_t;
    p4_us <= p3_us;
    p4_c  <= p3_c;
  end

  // P5: add cos on the diagonal and the cross-product terms
  logic signed [71:0] p5_e [9];
  logic signed [71:0] c60;
  logic signed [71:0] ee [6];
  logic signed [71:0] us [3];
  always_comb begin
    c60 = 72'(p4_c) <<< 30;
    for (int i = 0; i < 6; i++) ee[i] = 72'(p4_e[i]);
    for (int k = 0; k < 3; k++) us[k] = 72'(p4_us[k]);
  end

  always_ff @(posedge clk) begin
    p5_e[0] <= ee[0] + c60;
    p5_e[1] <= ee[3] - us[2];
    p5_e[2] <= ee[4] + us[1];
    p5_e[3] <= ee[3] + us[2];
    p5_e[4] <= ee[1] + c60;
    p5_e[5] <= ee[5] - us[0];
    p5_e[6] <= ee[4] - us[1];
    p5_e[7] <= ee[5] + us[0];
    p5_e[8] <= ee[2] + c60;
  end

  // Output register: round, saturate, identity on a zero axis
  always_ff @(posedge clk) begin
    if (zl[LAT-2]) begin
      result.r00 <= Q_ONE;
      result.r01 <= '0;
      result.r02 <= '0;
      result.r10 <= '0;
      result.r11 <= Q_ONE;
      result.r12 <= '0;
      result.r20 <= '0;
      result.r21 <= '0;
      result.r22 <= Q_ONE;
    end else begin
      result.r00 <= to_out(p5_e[0]);
      result.r01 <= to_out(p5_e[1]);
      result.r02 <= to_out(p5_e[2]);
      result.r10 <= to_out(p5_e[3]);
      result.r11 <= to_out(p5_e[4]);
      result.r12 <= to_out(p5_e[5]);
      result.r20 <= to_out(p5_e[6]);
      result.r21 <= to_out(p5_e[7]);
      result.r22 <= to_out(p5_e[8]);
    end
    result.degenerate <= zl[LAT-2];
  end

  `AAR_ASSERT_LATER(a_latency, start, LAT, done, "result missing after fixed latency")
  `AAR_ASSERT_LATER(a_zero_axis,
    start && (item.axis_x == 0) && (item.axis_y == 0) && (item.axis_z == 0), LAT,
    done && result.degenerate, "zero axis not flagged")
  `AAR_ASSERT_NOW(a_identity, done && result.degenerate,
    (result.r00 == Q_ONE) && (result.r11 == Q_ONE) && (result.r22 == Q_ONE) &&
    (result.r01 == 0), "degenerate result is not identity")
  `AAR_ASSERT_NOW(a_range, done,
    (result.r00 <= Q_ONE) && (result.r00 >= -Q_ONE) && (result.r12 <= Q_ONE) &&
    (result.r12 >= -Q_ONE), "entry outside +-1.0")

endmodule
